[hw/rtl/sbs_pkg.sv]
// Shared constants and result type for the scan breakpoint segmenter.
package sbs_pkg;

	localparam int NUM_BINS     = 360;
	localparam int MAX_CLUSTERS = 32;

	localparam int DIST_W    = 12;
	localparam int THR_W     = 12;
	localparam int THR_RESET = 200;
	localparam int ANGLE_W   = 9;
	localparam int MEAN_W    = 12;
	localparam int COUNT_W   = 9;
	localparam int INDEX_W   = 5;

	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int CNT_W  = $clog2(NUM_BINS + 1);
	localparam int OBJ_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int SUM_W  = $clog2(NUM_BINS * ((1 << DIST_W) - 1) + 1);
	localparam int STEP_W = $clog2(SUM_W + 1);

	// widths used to wrap internal values onto the output fields
	localparam int MID_X = (BIN_W > ANGLE_W) ? BIN_W : ANGLE_W;
	localparam int CNT_X = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int OBJ_X = (OBJ_W > INDEX_W) ? OBJ_W : INDEX_W;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_bin;
		logic [MEAN_W-1:0]  mean_distance;
		logic [COUNT_W-1:0] point_count;
		logic [INDEX_W-1:0] object_index;
		logic               object_valid;
		logic               scan_end;
	} res_t;

endpackage

[hw/rtl/sbs_div.sv]
// Bit-serial restoring divider: cluster sum by point count, one quotient bit per cycle.
module sbs_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [sbs_pkg::SUM_W-1:0] dividend,
	input  logic [sbs_pkg::CNT_W-1:0] divisor,
	output logic                     done,
	output logic [sbs_pkg::MEAN_W-1:0] quotient
);

	logic                      busy_q;
	logic                      done_q;
	logic [sbs_pkg::STEP_W-1:0] step_q;
	logic [sbs_pkg::SUM_W-1:0]  dvd_q;
	logic [sbs_pkg::CNT_W-1:0]  dvs_q;
	logic [sbs_pkg::CNT_W-1:0]  rem_q;

	logic [sbs_pkg::CNT_W:0] rem_sh;
	logic [sbs_pkg::CNT_W:0] rem_sub;
	logic                    ge;

	assign rem_sh  = {rem_q, dvd_q[sbs_pkg::SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= sbs_pkg::STEP_W'(sbs_pkg::SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == sbs_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sbs_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[sbs_pkg::CNT_W-1:0] : rem_sh[sbs_pkg::CNT_W-1:0];
		end
	end

	// mean never exceeds the largest distance, so the low bits hold it
	assign done     = done_q;
	assign quotient = dvd_q[sbs_pkg::MEAN_W-1:0];

endmodule

[hw/rtl/sbs_out.sv]
// Output register for result requests, decoupling the segmenter from the receiver.
module sbs_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sbs_pkg::res_t res_d,
	input  logic          out_stall,
	output logic          out_valid,
	output sbs_pkg::res_t res_q,
	output logic          free
);

	logic valid_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

[hw/rtl/scan_breakpoint_segmenter.sv]
// Top level of the scan breakpoint segmenter: bin intake, cluster tracking, result sequencing.
//
// Usage: one distance per angle bin enters on the in_valid/in_stall channel, NUM_BINS
// bins per scan in bin order. Objects leave on out_valid/out_stall, one request per
// object, the last request of each scan flagged by scan_end. The user writes jump_threshold
// on cfg_valid/cfg_ready (always ready) only while idle; the block does not enforce this.
// Sequencing: a bin that closes no cluster leaves the block idle. Each closed
// cluster runs the serial divider for the mean, one quotient bit per cycle
// over SUM_W bits (21 at 360 bins); the result then passes through S_EMIT and is
// loaded into the output register once it is free. A bin that closes two
// clusters (jump on the final bin) runs the divider for each in turn. The
// full-table end marker needs no division and goes from S_FINAL to S_EMIT.
// in_stall is high while a bin is being worked on or a result waits for room.
// A stalled receiver holds the output register; the block then holds in_stall
// until the pending result is loaded.
// Reset clears the scan state, the object count and the output valid flag, and
// restores jump_threshold to 200; no clearing pass is needed.
module scan_breakpoint_segmenter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sbs_pkg::DIST_W-1:0]  distance,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sbs_pkg::THR_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sbs_pkg::ANGLE_W-1:0] angle_bin,
	output logic [sbs_pkg::MEAN_W-1:0]  mean_distance,
	output logic [sbs_pkg::COUNT_W-1:0] point_count,
	output logic [sbs_pkg::INDEX_W-1:0] object_index,
	output logic                        object_valid,
	output logic                        scan_end
);

	typedef enum logic [1:0] {S_IDLE, S_FINAL, S_DIV, S_EMIT} state_t;

	state_t                     state_q;
	logic [sbs_pkg::THR_W-1:0]  thr_q;
	logic [sbs_pkg::DIST_W-1:0] prev_q;
	logic [sbs_pkg::BIN_W-1:0]  bin_q;
	logic [sbs_pkg::BIN_W-1:0]  start_q;
	logic [sbs_pkg::SUM_W-1:0]  sum_q;
	logic [sbs_pkg::OBJ_W-1:0]  cnt_q;
	logic                       fin_q;
	logic                       div_start_q;
	logic [sbs_pkg::SUM_W-1:0]  job_sum_q;
	logic [sbs_pkg::CNT_W-1:0]  job_dvs_q;
	sbs_pkg::res_t              pend_q;

	logic                        in_acc;
	logic [sbs_pkg::DIST_W-1:0]  diff;
	logic                        jump;
	logic                        room;
	logic                        is_first;
	logic                        is_last;
	logic [sbs_pkg::CNT_W-1:0]   jump_cnt;
	logic [sbs_pkg::CNT_W-1:0]   fin_cnt;
	logic [sbs_pkg::BIN_W-1:0]   last_bin;
	logic                        div_done;
	logic [sbs_pkg::MEAN_W-1:0]  div_quot;
	logic                        out_free;
	logic                        out_load;
	sbs_pkg::res_t               out_res;

	function automatic logic [sbs_pkg::ANGLE_W-1:0] mid_angle(
		input logic [sbs_pkg::BIN_W-1:0] first,
		input logic [sbs_pkg::BIN_W-1:0] last
	);
		logic [sbs_pkg::BIN_W:0]   s;
		logic [sbs_pkg::MID_X-1:0] ext;
		s   = {1'b0, first} + {1'b0, last};
		ext = sbs_pkg::MID_X'(s[sbs_pkg::BIN_W:1]);
		return ext[sbs_pkg::ANGLE_W-1:0];
	endfunction

	function automatic logic [sbs_pkg::COUNT_W-1:0] count_field(
		input logic [sbs_pkg::CNT_W-1:0] c
	);
		logic [sbs_pkg::CNT_X-1:0] ext;
		ext = sbs_pkg::CNT_X'(c);
		return ext[sbs_pkg::COUNT_W-1:0];
	endfunction

	function automatic logic [sbs_pkg::INDEX_W-1:0] index_field(
		input logic [sbs_pkg::OBJ_W-1:0] c
	);
		logic [sbs_pkg::OBJ_X-1:0] ext;
		ext = sbs_pkg::OBJ_X'(c);
		return ext[sbs_pkg::INDEX_W-1:0];
	endfunction

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;

	assign diff     = (distance > prev_q) ? distance - prev_q : prev_q - distance;
	assign jump     = diff > thr_q;
	assign room     = cnt_q < sbs_pkg::OBJ_W'(sbs_pkg::MAX_CLUSTERS);
	assign is_first = bin_q == '0;
	assign is_last  = bin_q == sbs_pkg::BIN_W'(sbs_pkg::NUM_BINS - 1);
	assign last_bin = sbs_pkg::BIN_W'(sbs_pkg::NUM_BINS - 1);
	// cluster before a jump spans start..bin-1
	assign jump_cnt = sbs_pkg::CNT_W'(bin_q - start_q);
	assign fin_cnt  = sbs_pkg::CNT_W'(sbs_pkg::NUM_BINS) - sbs_pkg::CNT_W'(start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= sbs_pkg::THR_W'(sbs_pkg::THR_RESET);
			prev_q      <= '0;
			bin_q       <= '0;
			start_q     <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_q <= distance;
						if (is_first) begin
							cnt_q   <= '0;
							start_q <= '0;
							sum_q   <= sbs_pkg::SUM_W'(distance);
							bin_q   <= sbs_pkg::BIN_W'(1);
						end else begin
							if (jump) begin
								start_q <= bin_q;
								sum_q   <= sbs_pkg::SUM_W'(distance);
							end else begin
								sum_q <= sum_q + sbs_pkg::SUM_W'(distance);
							end
							bin_q <= is_last ? '0 : bin_q + 1'b1;
							fin_q <= is_last;
							if (jump && room) begin
								cnt_q       <= cnt_q + 1'b1;
								div_start_q <= 1'b1;
								state_q     <= S_DIV;
							end else if (is_last) begin
								state_q <= S_FINAL;
							end
						end
					end
				end
				S_FINAL: begin
					fin_q <= 1'b0;
					if (room) begin
						cnt_q       <= cnt_q + 1'b1;
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= fin_q ? S_FINAL : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pending result and divider operands
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc && !is_first && jump && room) begin
			job_sum_q           <= sum_q;
			job_dvs_q           <= jump_cnt;
			pend_q.angle_bin    <= mid_angle(start_q, bin_q - 1'b1);
			pend_q.mean_distance <= '0;
			pend_q.point_count  <= count_field(jump_cnt);
			pend_q.object_index <= index_field(cnt_q);
			pend_q.object_valid <= 1'b1;
			pend_q.scan_end     <= 1'b0;
		end else if (state_q == S_FINAL) begin
			job_sum_q <= sum_q;
			job_dvs_q <= fin_cnt;
			if (room) begin
				pend_q.angle_bin    <= mid_angle(start_q, last_bin);
				pend_q.mean_distance <= '0;
				pend_q.point_count  <= count_field(fin_cnt);
				pend_q.object_index <= index_field(cnt_q);
				pend_q.object_valid <= 1'b1;
				pend_q.scan_end     <= 1'b1;
			end else begin
				// table full: end-of-scan marker
				pend_q.angle_bin     <= '0;
				pend_q.mean_distance <= '0;
				pend_q.point_count   <= '0;
				pend_q.object_index  <= '0;
				pend_q.object_valid  <= 1'b0;
				pend_q.scan_end      <= 1'b1;
			end
		end else if (state_q == S_DIV && div_done) begin
			pend_q.mean_distance <= div_quot;
		end
	end

	sbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (job_sum_q),
		.divisor  (job_dvs_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_load = (state_q == S_EMIT) && out_free;

	sbs_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.res_d     (pend_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (out_res),
		.free      (out_free)
	);

	assign angle_bin     = out_res.angle_bin;
	assign mean_distance = out_res.mean_distance;
	assign point_count   = out_res.point_count;
	assign object_index  = out_res.object_index;
	assign object_valid  = out_res.object_valid;
	assign scan_end      = out_res.scan_end;

`ifndef SYNTH
	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !object_valid |-> scan_end && point_count == '0)
		else $error("end marker without scan_end or with nonzero count");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside of a division");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sbs_pkg::OBJ_W'(sbs_pkg::MAX_CLUSTERS))
		else $error("object count exceeds table size");
`endif

endmodule
